### rtl/erm_pkg.sv
// ----------------------------------------------------------------------------
// erm_pkg: shared types and constants of the echo range bar mapper
// Field widths, register indexes, reset values and the record that travels
// from the front end to the mapping back end.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int unsigned ECHO_W    = 15;
  localparam int unsigned LIMIT_W   = 4;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Full channel level and the span of the two colour ramps together.
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
  localparam int unsigned        COLOR_SPAN = 510;

  localparam logic [LIMIT_W-1:0] DROPOUT_LIMIT_RST = 4'd5;
  localparam logic [ECHO_W-1:0]  MIN_VALID_RST     = 15'd116;
  localparam logic [ECHO_W-1:0]  MAX_VALID_RST     = 15'd23200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DROPOUT_LIMIT = 2'd0,
    CFG_MIN_VALID     = 2'd1,
    CFG_MAX_VALID     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] dropout_limit;
    logic [ECHO_W-1:0]  min_valid_us;
    logic [ECHO_W-1:0]  max_valid_us;
  } cfg_t;

  // One pending result: either an out-of-range report or a median to map.
  typedef struct packed {
    logic              no_echo;
    logic [ECHO_W-1:0] median_us;
  } rec_t;

endpackage

### rtl/echo_range_median_bar_mapper.sv
// ----------------------------------------------------------------------------
// echo_range_median_bar_mapper: ultrasonic echo to LED bar mapper
// Median-filters echo widths and turns the median into a bar length and a
// red-yellow-green colour, with out-of-range reporting after dropouts.
// ----------------------------------------------------------------------------
// Usage:
// Echo widths in microseconds enter through a queue-style port: a transfer
// happens at a clock edge where push is high and full is low. Results leave
// through a second queue-style port: the oldest result sits on the result
// ports while empty is low, and a transfer happens where pop is also high.
// A valid width always gives one result; an invalid width gives a result only
// once the dropout run has reached the configured limit.
// The block takes one item every cycle while full is low. A result passes
// from the combinational classification and median front end through the
// middle queue, the mapping pipeline (constant scaling, then the reciprocal
// multiply that divides by full scale) and the output queue.
// A four-entry queue between front and back and a two-entry output queue
// let each side stall on its own; full rises only when the middle queue
// fills while the receiver holds pop low.
// Reset empties both queues, clears the dropout run, write slot and fill
// count, and loads the register defaults. The sample ring needs no clearing,
// since the fill count keeps unwritten entries out of the median.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i by the
// user only while idle; the block itself does not enforce that.
// ----------------------------------------------------------------------------
module echo_range_median_bar_mapper #(
  parameter int unsigned WINDOW        = 5,
  parameter int unsigned BAR_LEDS      = 9,
  parameter int unsigned FULL_SCALE_US = 5800,
  parameter int unsigned LIT_W         = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [erm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [erm_pkg::ECHO_W-1:0]     cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic [erm_pkg::ECHO_W-1:0]     echo_us_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [LIT_W-1:0]               lit_count_o,
  output logic [erm_pkg::LEVEL_W-1:0]    red_level_o,
  output logic [erm_pkg::LEVEL_W-1:0]    green_level_o,
  output logic                           no_echo_o
);

  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 2;
  localparam int unsigned OUT_W     = LIT_W + 2 * erm_pkg::LEVEL_W + 1;

  erm_pkg::cfg_t cfg_q;
  erm_pkg::rec_t front_rec, mid_rec;
  logic          take, front_valid;
  logic          mid_full, mid_empty, mid_pop;
  logic          back_valid, out_full;
  logic [LIT_W-1:0]            back_lit;
  logic [erm_pkg::LEVEL_W-1:0] back_red, back_green;
  logic                        back_no_echo;
  logic [OUT_W-1:0]            out_word;

  // Configuration registers; writes to an unused index fall through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dropout_limit <= erm_pkg::DROPOUT_LIMIT_RST;
      cfg_q.min_valid_us  <= erm_pkg::MIN_VALID_RST;
      cfg_q.max_valid_us  <= erm_pkg::MAX_VALID_RST;
    end else if (cfg_we_i) begin
      priority if (cfg_idx_i == erm_pkg::CFG_DROPOUT_LIMIT) begin
        cfg_q.dropout_limit <= cfg_data_i[erm_pkg::LIMIT_W-1:0];
      end else if (cfg_idx_i == erm_pkg::CFG_MIN_VALID) begin
        cfg_q.min_valid_us <= cfg_data_i;
      end else if (cfg_idx_i == erm_pkg::CFG_MAX_VALID) begin
        cfg_q.max_valid_us <= cfg_data_i;
      end else begin
        cfg_q <= cfg_q;
      end
    end
  end

  // Input transfers are held off only by the middle queue.
  assign full = mid_full;
  assign take = push && !mid_full;

  erm_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .take_i      (take),
    .echo_us_i   (echo_us_i),
    .rec_valid_o (front_valid),
    .rec_o       (front_rec)
  );

  erm_fifo #(
    .WIDTH ($bits(erm_pkg::rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_rec),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rec),
    .empty_o (mid_empty)
  );

  erm_back #(
    .BAR_LEDS      (BAR_LEDS),
    .FULL_SCALE_US (FULL_SCALE_US),
    .LIT_W         (LIT_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_valid_i   (!mid_empty),
    .rec_i         (mid_rec),
    .rec_pop_o     (mid_pop),
    .out_full_i    (out_full),
    .out_valid_o   (back_valid),
    .lit_count_o   (back_lit),
    .red_level_o   (back_red),
    .green_level_o (back_green),
    .no_echo_o     (back_no_echo)
  );

  // Output queue acts as the skid stage toward the receiver.
  erm_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_valid),
    .data_i  ({back_lit, back_red, back_green, back_no_echo}),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_word),
    .empty_o (empty)
  );

  assign {lit_count_o, red_level_o, green_level_o, no_echo_o} = out_word;

endmodule

### rtl/erm_fifo.sv
// ----------------------------------------------------------------------------
// erm_fifo: small synchronous queue
// Register-based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module erm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### rtl/erm_front.sv
// ----------------------------------------------------------------------------
// erm_front: echo classification, dropout run and median window
// Checks each echo width against the valid window, keeps the dropout run,
// stores valid widths in the sample ring and picks the median of the ring.
// ----------------------------------------------------------------------------
module erm_front #(
  parameter int unsigned WINDOW = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  erm_pkg::cfg_t               cfg_i,
  input  logic                        take_i,
  input  logic [erm_pkg::ECHO_W-1:0]  echo_us_i,
  output logic                        rec_valid_o,
  output erm_pkg::rec_t               rec_o
);

  localparam int unsigned SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);

  logic [erm_pkg::ECHO_W-1:0]  ring_q [WINDOW];
  logic [erm_pkg::ECHO_W-1:0]  ring_nx [WINDOW];
  logic [SW-1:0]               slot_q, slot_d;
  logic [CW-1:0]               fill_q, fill_d;
  logic [erm_pkg::LIMIT_W-1:0] run_q, run_d;
  logic [CW-1:0]               below [WINDOW];
  logic [CW-1:0]               same [WINDOW];
  logic [CW-1:0]               rank_k;
  logic [erm_pkg::ECHO_W-1:0]  median;
  logic                        echo_ok;
  logic                        limit_hit;

  assign echo_ok = (echo_us_i != '0) && (echo_us_i >= cfg_i.min_valid_us)
                   && (echo_us_i <= cfg_i.max_valid_us);

  // Dropout run saturates at the limit; reaching it reports out of range.
  always_comb begin
    run_d = run_q;
    if (take_i) begin
      if (echo_ok) begin
        run_d = '0;
      end else if (run_q < cfg_i.dropout_limit) begin
        run_d = run_q + erm_pkg::LIMIT_W'(1);
      end
    end
  end

  assign limit_hit = !(run_d < cfg_i.dropout_limit);

  always_comb begin
    slot_d = slot_q;
    fill_d = fill_q;
    if (take_i && echo_ok) begin
      slot_d = (slot_q == SW'(WINDOW - 1)) ? '0 : slot_q + SW'(1);
      if (fill_q < CW'(WINDOW)) begin
        fill_d = fill_q + CW'(1);
      end
    end
  end

  // Ring contents as they stand once this width is written.
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      ring_nx[i] = (slot_q == SW'(i)) ? echo_us_i : ring_q[i];
    end
  end

  // Rank selection: an entry is the median when the wanted rank falls
  // within its run of equal values. Only filled entries take part.
  assign rank_k = fill_d >> 1;

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      below[i] = '0;
      same[i]  = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (CW'(j) < fill_d) begin
          if (ring_nx[j] < ring_nx[i]) begin
            below[i] = below[i] + CW'(1);
          end else if (ring_nx[j] == ring_nx[i]) begin
            same[i] = same[i] + CW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    median = '0;
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if ((CW'(i) < fill_d) && (below[i] <= rank_k) && (rank_k < below[i] + same[i])) begin
        median = ring_nx[i];
      end
    end
  end

  assign rec_valid_o     = take_i && (echo_ok || limit_hit);
  assign rec_o.no_echo   = !echo_ok;
  assign rec_o.median_us = echo_ok ? median : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
      run_q  <= '0;
    end else begin
      slot_q <= slot_d;
      fill_q <= fill_d;
      run_q  <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && echo_ok) begin
      ring_q[slot_q] <= echo_us_i;
    end
  end

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(WINDOW))
    else $error("fill count beyond window depth");

  a_slot_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW+1)'(slot_q) < (SW+1)'(WINDOW))
    else $error("write slot beyond window depth");

  a_valid_clears_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && echo_ok) |=> (run_q == '0) && (fill_q != '0))
    else $error("valid echo did not clear dropout run or fill the ring");

  a_valid_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && echo_ok) |-> (rec_valid_o && !rec_o.no_echo))
    else $error("valid echo produced no median record");

endmodule

### rtl/erm_back.sv
// ----------------------------------------------------------------------------
// erm_back: median to bar length and colour mapping
// Two-stage pipeline: constant scaling, then exact division by full scale
// through a reciprocal multiply, with the result selection.
// ----------------------------------------------------------------------------
module erm_back #(
  parameter int unsigned BAR_LEDS      = 9,
  parameter int unsigned FULL_SCALE_US = 5800,
  parameter int unsigned LIT_W         = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rec_valid_i,
  input  erm_pkg::rec_t                rec_i,
  output logic                         rec_pop_o,
  input  logic                         out_full_i,
  output logic                         out_valid_o,
  output logic [LIT_W-1:0]             lit_count_o,
  output logic [erm_pkg::LEVEL_W-1:0]  red_level_o,
  output logic [erm_pkg::LEVEL_W-1:0]  green_level_o,
  output logic                         no_echo_o
);

  localparam int unsigned MAXK  = (BAR_LEDS - 1 > erm_pkg::COLOR_SPAN) ? BAR_LEDS - 1
                                  : erm_pkg::COLOR_SPAN;
  localparam int unsigned PW    = $clog2(FULL_SCALE_US * MAXK + 1);
  localparam int unsigned LW    = $clog2(FULL_SCALE_US);
  localparam int unsigned SH    = PW + LW;
  // Rounded-up reciprocal: exact floor division for every product below 2**PW.
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(FULL_SCALE_US) - 64'd1)
                                  / 64'(FULL_SCALE_US);
  localparam int unsigned RW    = $clog2(RECIP + 1);
  localparam int unsigned MW    = PW + RW;
  localparam int unsigned XW    = erm_pkg::ECHO_W + 10;

  localparam logic [erm_pkg::ECHO_W-1:0] FS = erm_pkg::ECHO_W'(FULL_SCALE_US);

  logic                         s1_v_q, s1_no_echo_q, s1_over_q, s1_lower_q;
  logic [PW-1:0]                s1_bar_q, s1_col_q;
  logic                         s2_v_q, s2_no_echo_q;
  logic [LIT_W-1:0]             s2_lit_q;
  logic [erm_pkg::LEVEL_W-1:0]  s2_red_q, s2_green_q;
  logic                         s1_ready, s2_ready;

  logic                         over, lower;
  logic [erm_pkg::ECHO_W-1:0]   clip, ramp;
  logic [XW-1:0]                bar_prod, col_prod;
  logic [MW-1:0]                bar_quot, col_quot;
  logic [LIT_W-1:0]             lit_d;
  logic [erm_pkg::LEVEL_W-1:0]  red_d, green_d, ramp_lvl;

  assign s2_ready  = !s2_v_q || !out_full_i;
  assign s1_ready  = !s1_v_q || s2_ready;
  assign rec_pop_o = s1_ready;

  // Stage one: clip to full scale and scale by the small constants.
  always_comb begin
    over     = rec_i.median_us > FS;
    clip     = over ? FS : rec_i.median_us;
    lower    = ({1'b0, clip} << 1) < {1'b0, FS};
    ramp     = lower ? clip : FS - clip;
    bar_prod = over ? '0 : XW'(rec_i.median_us) * XW'(BAR_LEDS - 1);
    col_prod = XW'(ramp) * XW'(erm_pkg::COLOR_SPAN);
  end

  // Stage two: divide by full scale and pick the channels.
  always_comb begin
    bar_quot = MW'(s1_bar_q) * MW'(RECIP);
    col_quot = MW'(s1_col_q) * MW'(RECIP);
    ramp_lvl = col_quot[SH +: erm_pkg::LEVEL_W];
    if (s1_no_echo_q) begin
      lit_d   = '0;
      red_d   = erm_pkg::LEVEL_MAX;
      green_d = '0;
    end else begin
      lit_d   = s1_over_q ? '0 : bar_quot[SH +: LIT_W] + LIT_W'(1);
      red_d   = s1_lower_q ? erm_pkg::LEVEL_MAX : ramp_lvl;
      green_d = s1_lower_q ? ramp_lvl : erm_pkg::LEVEL_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= rec_valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_no_echo_q <= rec_i.no_echo;
      s1_over_q    <= over;
      s1_lower_q   <= lower;
      s1_bar_q     <= PW'(bar_prod);
      s1_col_q     <= PW'(col_prod);
    end
    if (s2_ready) begin
      s2_no_echo_q <= s1_no_echo_q;
      s2_lit_q     <= lit_d;
      s2_red_q     <= red_d;
      s2_green_q   <= green_d;
    end
  end

  assign out_valid_o   = s2_v_q;
  assign lit_count_o   = s2_lit_q;
  assign red_level_o   = s2_red_q;
  assign green_level_o = s2_green_q;
  assign no_echo_o     = s2_no_echo_q;

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the echo range median bar mapper
// Feeds echo widths through the queue-style input, predicts the bar results
// with a model of the block kept inside the bench or takes them from pinned
// plan rows, and compares each result popped from the output queue field by field.
// ----------------------------------------------------------------------------
module testbench;

  // Field widths as the block uses them.
  localparam int unsigned ECHO_W    = erm_pkg::ECHO_W;
  localparam int unsigned LIMIT_W   = erm_pkg::LIMIT_W;
  localparam int unsigned LEVEL_W   = erm_pkg::LEVEL_W;
  localparam int unsigned CFG_IDX_W = erm_pkg::CFG_IDX_W;

  // Block configuration. The bench instance uses the same values.
  localparam int unsigned WINDOW        = 5;
  localparam int unsigned BAR_LEDS      = 9;
  localparam int unsigned FULL_SCALE_US = 5800;
  localparam int unsigned LIT_W         = 4;

  // Run control.
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_MAX    = 5000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned CHOKE_CYCLES  = 300;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 75;

  // Register index that lies past the end of the register list.
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX = 2'd3;

  // One bar result as it shows on the output ports.
  typedef struct packed {
    logic [LIT_W-1:0]   lit;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic               no_echo;
  } bar_t;

  localparam bar_t NO_BAR      = '0;
  localparam bar_t DROP_REPORT = '{lit: '0, red: erm_pkg::LEVEL_MAX, green: '0,
                                   no_echo: 1'b1};

  // Directed plan: each row is either an echo transfer or a register write.
  // A pinned row carries its result typed in; the rest go to the predictor.
  typedef enum logic {DO_ITEM, DO_WRITE} row_kind_e;
  typedef enum logic [1:0] {PIN_NONE, PIN_RESULT, PIN_SILENT} pin_e;

  typedef struct packed {
    row_kind_e            kind;
    pin_e                 pin;
    logic [CFG_IDX_W-1:0] idx;   // unused on item rows
    logic [ECHO_W-1:0]    data;  // echo width or register value
    bar_t                 want;
  } plan_row_t;

  localparam int unsigned PLAN_ROWS = 30;

  // Default settings are limit 5 and a valid window of 116..23200 us.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // First reading after reset: the median of a single entry.
    '{DO_ITEM,  PIN_RESULT, SPARE_IDX, 15'd116,   '{4'd1, 8'd255, 8'd10, 1'b0}},
    // Full scale: all nine LEDs, pure green.
    '{DO_ITEM,  PIN_RESULT, SPARE_IDX, 15'd5800,  '{4'd9, 8'd0, 8'd255, 1'b0}},
    '{DO_ITEM,  PIN_NONE,   SPARE_IDX, 15'd23200, NO_BAR},
    // Dropouts of every kind; the fifth in a row reaches the limit.
    '{DO_ITEM,  PIN_SILENT, SPARE_IDX, 15'd23201, NO_BAR},
    '{DO_ITEM,  PIN_SILENT, SPARE_IDX, 15'd115,   NO_BAR},
    '{DO_ITEM,  PIN_SILENT, SPARE_IDX, 15'd0,     NO_BAR},
    '{DO_ITEM,  PIN_SILENT, SPARE_IDX, 15'd32767, NO_BAR},
    '{DO_ITEM,  PIN_RESULT, SPARE_IDX, 15'd1,     DROP_REPORT},
    // The run saturates at the limit, so every further dropout reports.
    '{DO_ITEM,  PIN_RESULT, SPARE_IDX, 15'd0,     DROP_REPORT},
    // A valid width clears the run; the ring fills, wraps and goes past
    // full scale.
    '{DO_ITEM,  PIN_NONE,   SPARE_IDX, 15'd2900,  NO_BAR},
    '{DO_ITEM,  PIN_NONE,   SPARE_IDX, 15'd2899,  NO_BAR},
    '{DO_ITEM,  PIN_NONE,   SPARE_IDX, 15'd6000,  NO_BAR},
    '{DO_ITEM,  PIN_NONE,   SPARE_IDX, 15'd7000,  NO_BAR},
    '{DO_ITEM,  PIN_NONE,   SPARE_IDX, 15'd8000,  NO_BAR},
    // Upper data bits are dropped, leaving a zero limit: instant report.
    '{DO_WRITE, PIN_NONE,   erm_pkg::CFG_DROPOUT_LIMIT, 15'h7FF0, NO_BAR},
    '{DO_ITEM,  PIN_RESULT, SPARE_IDX, 15'd0,     DROP_REPORT},
    // Build a run of three under a limit of four, then drop the limit to two.
    '{DO_WRITE, PIN_NONE,   erm_pkg::CFG_DROPOUT_LIMIT, 15'd4, NO_BAR},
    '{DO_ITEM,  PIN_NONE,   SPARE_IDX, 15'd1,     NO_BAR},
    '{DO_ITEM,  PIN_NONE,   SPARE_IDX, 15'd1,     NO_BAR},
    '{DO_ITEM,  PIN_NONE,   SPARE_IDX, 15'd1,     NO_BAR},
    '{DO_WRITE, PIN_NONE,   erm_pkg::CFG_DROPOUT_LIMIT, 15'd2, NO_BAR},
    '{DO_ITEM,  PIN_RESULT, SPARE_IDX, 15'd0,     DROP_REPORT},
    // An inverted window accepts nothing.
    '{DO_WRITE, PIN_NONE,   erm_pkg::CFG_MIN_VALID, 15'd20000, NO_BAR},
    '{DO_WRITE, PIN_NONE,   erm_pkg::CFG_MAX_VALID, 15'd10000, NO_BAR},
    '{DO_ITEM,  PIN_RESULT, SPARE_IDX, 15'd15000, DROP_REPORT},
    // A write past the register list must leave the window alone.
    '{DO_WRITE, PIN_NONE,   SPARE_IDX, 15'h7FFF,  NO_BAR},
    '{DO_ITEM,  PIN_RESULT, SPARE_IDX, 15'd20000, DROP_REPORT},
    '{DO_WRITE, PIN_NONE,   erm_pkg::CFG_MIN_VALID, erm_pkg::MIN_VALID_RST, NO_BAR},
    '{DO_WRITE, PIN_NONE,   erm_pkg::CFG_MAX_VALID, erm_pkg::MAX_VALID_RST, NO_BAR},
    '{DO_WRITE, PIN_NONE,   erm_pkg::CFG_DROPOUT_LIMIT,
      15'(erm_pkg::DROPOUT_LIMIT_RST), NO_BAR}
  };

  // Ports of the block.
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [ECHO_W-1:0]    cfg_data;
  logic                 push;
  logic                 full;
  logic [ECHO_W-1:0]    echo_us;
  logic                 empty;
  logic                 pop;
  logic [LIT_W-1:0]     lit_count;
  logic [LEVEL_W-1:0]   red_level;
  logic [LEVEL_W-1:0]   green_level;
  logic                 no_echo;

  // Bench copy of the block state and registers.
  logic [LIMIT_W-1:0] drop_limit = erm_pkg::DROPOUT_LIMIT_RST;
  logic [ECHO_W-1:0]  min_us     = erm_pkg::MIN_VALID_RST;
  logic [ECHO_W-1:0]  max_us     = erm_pkg::MAX_VALID_RST;
  logic [ECHO_W-1:0]  ring [WINDOW];
  int unsigned        wr_slot    = 0;
  int unsigned        fill       = 0;
  logic [LIMIT_W-1:0] drop_run   = '0;

  // Bars still owed by the block, oldest first.
  bar_t        owed_bars [$];
  pin_e        pin_mode = PIN_NONE;
  bar_t        pin_bar  = NO_BAR;

  int unsigned errors   = 0;
  int unsigned cycles   = 0;
  int unsigned tx_burst = 0;
  int unsigned rx_burst = 0;
  int unsigned drop_left = 0;
  bit          choke_req    = 1'b0;
  bit          choke_active = 1'b0;

  echo_range_median_bar_mapper #(
    .WINDOW        (WINDOW),
    .BAR_LEDS      (BAR_LEDS),
    .FULL_SCALE_US (FULL_SCALE_US),
    .LIT_W         (LIT_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .push          (push),
    .full          (full),
    .echo_us_i     (echo_us),
    .empty         (empty),
    .pop           (pop),
    .lit_count_o   (lit_count),
    .red_level_o   (red_level),
    .green_level_o (green_level),
    .no_echo_o     (no_echo)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Median of the filled part of the ring: sort a copy, take rank n/2.
  function automatic int unsigned ring_median(int unsigned n);
    logic [ECHO_W-1:0] s [WINDOW];
    logic [ECHO_W-1:0] t;
    int j;
    for (int i = 0; i < n; i++) s[i] = ring[i];
    for (int i = 1; i < n; i++) begin
      t = s[i];
      j = i;
      while (j > 0 && s[j-1] > t) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = t;
    end
    return s[n/2];
  endfunction

  // Advances the bench state by one echo width and works out the bar it
  // causes, if any.
  function automatic void map_echo(input logic [ECHO_W-1:0] us, output bit has,
                                   output bar_t bar);
    int unsigned m;
    int unsigned c;
    int unsigned lit;
    bar = NO_BAR;
    has = 1'b0;
    if (us == 0 || us < min_us || us > max_us) begin
      if (drop_run < drop_limit) drop_run++;
      if (drop_run >= drop_limit) begin
        has = 1'b1;
        bar = DROP_REPORT;
      end
      return;
    end
    drop_run      = '0;
    ring[wr_slot] = us;
    wr_slot       = (wr_slot == WINDOW - 1) ? 0 : wr_slot + 1;
    if (fill < WINDOW) fill++;
    m = ring_median(fill);
    if (m > FULL_SCALE_US) begin
      lit = 0;
    end else begin
      lit = m * (BAR_LEDS - 1) / FULL_SCALE_US + 1;
      if (lit > BAR_LEDS) lit = BAR_LEDS;
    end
    // Red-yellow-green ramp: below half scale red is full and green grows,
    // above it green is full and red falls away.
    c = (m > FULL_SCALE_US) ? FULL_SCALE_US : m;
    if (2 * c < FULL_SCALE_US) begin
      bar.red   = erm_pkg::LEVEL_MAX;
      bar.green = LEVEL_W'(c * erm_pkg::COLOR_SPAN / FULL_SCALE_US);
    end else begin
      bar.red   = LEVEL_W'((FULL_SCALE_US - c) * erm_pkg::COLOR_SPAN / FULL_SCALE_US);
      bar.green = erm_pkg::LEVEL_MAX;
    end
    bar.lit = LIT_W'(lit);
    has     = 1'b1;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
    errors++;
  endtask

  // Idle length for either side: mostly short, a few long, and now and then
  // a stretch of back-to-back transfers.
  function automatic int unsigned next_gap(inout int unsigned burst);
    int unsigned r;
    if (burst != 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ECHO_W-1:0] pick_dropout();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return (min_us > 1) ? ECHO_W'($urandom_range(1, min_us - 1)) : '0;
      2: return (max_us < 15'h7FFF) ? ECHO_W'($urandom_range(max_us + 1, 32767)) : '0;
      default: return (max_us < 15'h7FFF) ? 15'h7FFF : '0;
    endcase
  endfunction

  // Mostly valid widths biased toward the colour ramp, with dropout runs
  // long enough to cross the limit, edge values and plain noise mixed in.
  function automatic logic [ECHO_W-1:0] pick_echo();
    int unsigned r;
    int unsigned lo;
    int unsigned hi_soft;
    lo      = (min_us == 0) ? 1 : min_us;
    hi_soft = (max_us > 7000) ? 7000 : max_us;
    if (drop_left != 0) begin
      drop_left--;
      return pick_dropout();
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      drop_left = $urandom_range(1, 17);
      return pick_dropout();
    end
    if (r < 70 && lo <= max_us) begin
      if (lo <= hi_soft && $urandom_range(0, 3) != 0)
        return ECHO_W'($urandom_range(lo, hi_soft));
      return ECHO_W'($urandom_range(lo, max_us));
    end
    if (r < 85) begin
      case ($urandom_range(0, 9))
        0: return '0;
        1: return 15'd1;
        2: return (min_us == 0) ? '0 : ECHO_W'(min_us - 1);
        3: return min_us;
        4: return max_us;
        5: return ECHO_W'(max_us + 1);
        6: return 15'd5800;
        7: return 15'd5799;
        8: return 15'd5801;
        default: return 15'h7FFF;
      endcase
    end
    return ECHO_W'($urandom_range(0, 32767));
  endfunction

  // Offers one echo width and returns at the falling edge after its
  // transfer, with push still high so a following item can go back to back.
  task automatic send_echo(logic [ECHO_W-1:0] us);
    int unsigned gap;
    gap = choke_active ? 0 : next_gap(tx_burst);
    if (gap != 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push    = 1'b1;
    echo_us = us;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ECHO_W-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we   = 1'b0;
    @(negedge clk_i);
  endtask

  // Stops the input, waits for every owed bar, then lets the pipeline run
  // dry, since a dropout below the limit may still be in flight with no bar
  // to show for it.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    push   = 1'b0;
    while (owed_bars.size() != 0 && waited < SETTLE_MAX) begin
      @(negedge clk_i);
      waited++;
    end
    if (owed_bars.size() != 0) begin
      flag_mismatch("bars never delivered", owed_bars.size(), 0);
      owed_bars.delete();
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Monitor: everything is sampled at the rising edge, where the inputs
  // driven at the falling edge are long settled. Register writes and input
  // transfers update the bench state; output transfers are checked against
  // the oldest owed bar.
  always @(posedge clk_i) begin
    bit   has;
    bar_t bar;
    cycles++;
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_idx)
          erm_pkg::CFG_DROPOUT_LIMIT: drop_limit = cfg_data[LIMIT_W-1:0];
          erm_pkg::CFG_MIN_VALID:     min_us     = cfg_data;
          erm_pkg::CFG_MAX_VALID:     max_us     = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        map_echo(echo_us, has, bar);
        // A pinned directed row overrides what the predictor says.
        if (pin_mode == PIN_RESULT) begin
          has = 1'b1;
          bar = pin_bar;
        end else if (pin_mode == PIN_SILENT) begin
          has = 1'b0;
        end
        pin_mode = PIN_NONE;
        if (has) owed_bars.push_back(bar);
      end
      if (pop && !empty) begin
        if (owed_bars.size() == 0) begin
          flag_mismatch("unexpected bar, lit_count", lit_count, 0);
        end else begin
          bar = owed_bars.pop_front();
          if (lit_count != bar.lit) flag_mismatch("lit_count", lit_count, bar.lit);
          if (red_level != bar.red) flag_mismatch("red_level", red_level, bar.red);
          if (green_level != bar.green)
            flag_mismatch("green_level", green_level, bar.green);
          if (no_echo != bar.no_echo) flag_mismatch("no_echo", no_echo, bar.no_echo);
        end
      end
    end
  end

  // Receiver: pops with random stalls. On request it holds pop low for a
  // long stretch so that both internal queues fill and full rises.
  initial begin
    int unsigned gap;
    pop = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (choke_req) begin
        choke_req    = 1'b0;
        choke_active = 1'b1;
        pop          = 1'b0;
        repeat (CHOKE_CYCLES) @(negedge clk_i);
        choke_active = 1'b0;
      end
      gap = next_gap(rx_burst);
      if (gap != 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop = 1'b1;
      @(negedge clk_i);
    end
  end

  // A run that hangs ends here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  // Main sequence: reset, the directed plan, then random phases, each under
  // its own register setting.
  initial begin
    int unsigned limit_val;
    int unsigned min_val;
    int unsigned max_val;
    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = erm_pkg::CFG_DROPOUT_LIMIT;
    cfg_data = '0;
    push     = 1'b0;
    echo_us  = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == DO_WRITE) begin
        settle();
        write_reg(PLAN[i].idx, PLAN[i].data);
      end else begin
        pin_mode = PLAN[i].pin;
        pin_bar  = PLAN[i].want;
        send_echo(PLAN[i].data);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      // The first phases pin the defaults and register extremes; the last ones draw at
      // random and may invert the window, the very last one with both bounds in 0..30000.
      case (p)
        0: begin limit_val = 5;  min_val = 116;   max_val = 23200; end
        1: begin limit_val = 1;  min_val = 0;     max_val = 30000; end
        2: begin limit_val = 15; min_val = 30000; max_val = 30000; end
        3: begin limit_val = 0;  min_val = 1;     max_val = 5800;  end
        4: begin
          limit_val = $urandom_range(0, 15);
          min_val   = $urandom_range(0, 3000);
          max_val   = $urandom_range(2000, 30000);
        end
        default: begin
          limit_val = $urandom_range(0, 15);
          min_val   = $urandom_range(0, 30000);
          max_val   = $urandom_range(0, 30000);
        end
      endcase
      settle();
      // Random upper bits on the limit write exercise the masking.
      write_reg(erm_pkg::CFG_DROPOUT_LIMIT,
                {(ECHO_W-LIMIT_W)'($urandom_range(0, 2047)), LIMIT_W'(limit_val)});
      write_reg(erm_pkg::CFG_MIN_VALID, ECHO_W'(min_val));
      write_reg(erm_pkg::CFG_MAX_VALID, ECHO_W'(max_val));
      drop_left = 0;
      if (p == 0 || p == 3) choke_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_echo(pick_echo());
    end

    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
